[sv/timed_message_queue_defines.svh]
// assertion macros for the timed message queue
`ifndef TIMED_MESSAGE_QUEUE_DEFINES_SVH
`define TIMED_MESSAGE_QUEUE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TMQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define TMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/tmq_pkg.sv]
// shared types and constants of the timed message queue
`timescale 1ns / 1ps

package tmq_pkg;

	localparam int MAX_RESULTS = 16;
	localparam int CNT_W = $clog2(MAX_RESULTS);

	localparam logic FUNC_POST = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic [1:0] KIND_ACCEPT   = 2'd0;
	localparam logic [1:0] KIND_FULL     = 2'd1;
	localparam logic [1:0] KIND_DISPATCH = 2'd2;

	typedef struct packed {
		logic load;
		logic post;
		logic pop;
	} cmd_t;

	typedef struct packed {
		logic head_due;
		logic last_pop;
	} status_t;

endpackage

[sv/tmq_ctrl.sv]
// controller state machine of the timed message queue
`timescale 1ns / 1ps

module tmq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            func,
	input  tmq_pkg::status_t status,
	output logic            busy,
	output tmq_pkg::cmd_t   cmd
);
	import tmq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_POST = 3'b010,
		ST_TICK = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd.load = 1'b0;
		cmd.post = 1'b0;
		cmd.pop = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = (func == FUNC_TICK) ? ST_TICK : ST_POST;
				end
			end
			ST_POST: begin
				cmd.post = 1'b1;
				state_d = ST_IDLE;
			end
			ST_TICK: begin
				if (status.head_due) begin
					cmd.pop = 1'b1;
					if (status.last_pop) begin
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[sv/tmq_datapath.sv]
// sorted shift-register queue, input latches and result register
`timescale 1ns / 1ps
`include "timed_message_queue_defines.svh"

module tmq_datapath #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tmq_pkg::cmd_t    cmd,
	output tmq_pkg::status_t status,
	input  logic [7:0]       sender_id,
	input  logic [7:0]       receiver_id,
	input  logic [7:0]       msg_code,
	input  logic [31:0]      due_time,
	input  logic [31:0]      extra_tag,
	input  logic [31:0]      current_time,
	output logic             result_valid,
	output logic [1:0]       kind,
	output logic [7:0]       out_sender,
	output logic [7:0]       out_receiver,
	output logic [7:0]       out_code,
	output logic [31:0]      out_tag,
	output logic             is_last
);
	import tmq_pkg::*;

	localparam int OW = $clog2(QUEUE_DEPTH + 1);

	logic [31:0] time_q [QUEUE_DEPTH];
	logic [7:0]  snd_q  [QUEUE_DEPTH];
	logic [7:0]  rcv_q  [QUEUE_DEPTH];
	logic [7:0]  code_q [QUEUE_DEPTH];
	logic [31:0] tag_q  [QUEUE_DEPTH];

	logic [OW-1:0]    occ_q;
	logic [CNT_W-1:0] cnt_q;

	logic [7:0]  snd_in_q, rcv_in_q, code_in_q;
	logic [31:0] due_in_q, tag_in_q, now_q;

	logic        done_q, last_q;
	logic [1:0]  kind_q;
	logic [7:0]  out_snd_q, out_rcv_q, out_code_q;
	logic [31:0] out_tag_q;

	logic [QUEUE_DEPTH-1:0] keep;
	logic [QUEUE_DEPTH-1:0] ins_here;
	logic full, next_due;

	// entries that stay ahead of the new message form a prefix
	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			keep[i] = (OW'(i) < occ_q) && (time_q[i] <= due_in_q);
		end
		ins_here[0] = !keep[0];
		for (int i = 1; i < QUEUE_DEPTH; i++) begin
			ins_here[i] = !keep[i] && keep[i-1];
		end
	end

	assign full = (occ_q == OW'(QUEUE_DEPTH));
	assign status.head_due = (occ_q != '0) && (time_q[0] < now_q);
	assign next_due = (occ_q > OW'(1)) && (time_q[1] < now_q);
	assign status.last_pop = !next_due || (cnt_q == CNT_W'(MAX_RESULTS - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			snd_in_q <= sender_id;
			rcv_in_q <= receiver_id;
			code_in_q <= msg_code;
			due_in_q <= due_time;
			tag_in_q <= extra_tag;
			now_q <= current_time;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post && !full) begin
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				if (ins_here[i]) begin
					time_q[i] <= due_in_q;
					snd_q[i] <= snd_in_q;
					rcv_q[i] <= rcv_in_q;
					code_q[i] <= code_in_q;
					tag_q[i] <= tag_in_q;
				end else if (!keep[i] && i > 0) begin
					time_q[i] <= time_q[(i > 0) ? i - 1 : 0];
					snd_q[i] <= snd_q[(i > 0) ? i - 1 : 0];
					rcv_q[i] <= rcv_q[(i > 0) ? i - 1 : 0];
					code_q[i] <= code_q[(i > 0) ? i - 1 : 0];
					tag_q[i] <= tag_q[(i > 0) ? i - 1 : 0];
				end
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
				time_q[i] <= time_q[i+1];
				snd_q[i] <= snd_q[i+1];
				rcv_q[i] <= rcv_q[i+1];
				code_q[i] <= code_q[i+1];
				tag_q[i] <= tag_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.post || cmd.pop;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.post && !full) begin
				occ_q <= occ_q + OW'(1);
			end else if (cmd.pop) begin
				occ_q <= occ_q - OW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post) begin
			kind_q <= full ? KIND_FULL : KIND_ACCEPT;
			out_snd_q <= '0;
			out_rcv_q <= '0;
			out_code_q <= '0;
			out_tag_q <= '0;
			last_q <= 1'b1;
		end else if (cmd.pop) begin
			kind_q <= KIND_DISPATCH;
			out_snd_q <= snd_q[0];
			out_rcv_q <= rcv_q[0];
			out_code_q <= code_q[0];
			out_tag_q <= tag_q[0];
			last_q <= status.last_pop;
		end
	end

	assign result_valid = done_q;
	assign kind = kind_q;
	assign out_sender = out_snd_q;
	assign out_receiver = out_rcv_q;
	assign out_code = out_code_q;
	assign out_tag = out_tag_q;
	assign is_last = last_q;

	`TMQ_ASSERT_SAME(a_occ_range, clk, arst_n, 1'b1, occ_q <= OW'(QUEUE_DEPTH), "occupancy over depth")
	`TMQ_ASSERT_SAME(a_head_sorted, clk, arst_n, occ_q > OW'(1), time_q[0] <= time_q[1], "queue head out of order")
	`TMQ_ASSERT_NEXT(a_pop_occ, clk, arst_n, cmd.pop, occ_q == $past(occ_q) - OW'(1), "pop did not shrink queue")
	`TMQ_ASSERT_NEXT(a_ins_occ, clk, arst_n, cmd.post && !full, occ_q == $past(occ_q) + OW'(1), "insert did not grow queue")
	`TMQ_ASSERT_SAME(a_post_last, clk, arst_n, done_q && kind_q != KIND_DISPATCH, last_q, "post status without last mark")

endmodule

[sv/timed_message_queue.sv]
// top level of the timed message queue
`timescale 1ns / 1ps
// usage:
// a command is taken at a rising edge with start high and busy low. func 0 posts a
// message (sender_id, receiver_id, msg_code, due_time, extra_tag) into a queue kept
// sorted by due_time, behind entries of equal time. func 1 is a tick carrying
// current_time: every held entry with a time strictly earlier leaves, head first.
// each result shows for one cycle with result_valid high; the receiver cannot stall.
// a post gives one result (kind accepted or full) with is_last set: the take latches
// the inputs, then the POST state writes the result register; busy stays high for one
// cycle, so the next command is taken only after that result is registered. a tick
// gives one dispatched message per cycle from the queue head, up to 16 per tick,
// is_last on the final one; busy drops with the last pop, so the port stays held until
// the tick is through. a tick with nothing due gives no result and frees the port.
// the rate is set by the single shift-register queue, which moves at most once per cycle.
// reset empties the queue and returns the controller to idle; no clearing pass.

module timed_message_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        func,
	input  logic [7:0]  sender_id,
	input  logic [7:0]  receiver_id,
	input  logic [7:0]  msg_code,
	input  logic [31:0] due_time,
	input  logic [31:0] extra_tag,
	input  logic [31:0] current_time,
	output logic        result_valid,
	output logic [1:0]  kind,
	output logic [7:0]  out_sender,
	output logic [7:0]  out_receiver,
	output logic [7:0]  out_code,
	output logic [31:0] out_tag,
	output logic        is_last
);
	import tmq_pkg::*;

	cmd_t    cmd;
	status_t status;

	tmq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	tmq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.sender_id    (sender_id),
		.receiver_id  (receiver_id),
		.msg_code     (msg_code),
		.due_time     (due_time),
		.extra_tag    (extra_tag),
		.current_time (current_time),
		.result_valid (result_valid),
		.kind         (kind),
		.out_sender   (out_sender),
		.out_receiver (out_receiver),
		.out_code     (out_code),
		.out_tag      (out_tag),
		.is_last      (is_last)
	);

endmodule

[tb/sv/timed_message_queue_tb.sv]
// testbench for the timed message queue with directed and random transactions
`timescale 1ns / 1ps

module timed_message_queue_tb;

	import tmq_pkg::*;

	localparam int QUEUE_DEPTH  = 16;
	localparam int RANDOM_ITEMS = 460;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		logic        func;
		logic [7:0]  sender;
		logic [7:0]  receiver;
		logic [7:0]  code;
		logic [31:0] due;
		logic [31:0] tag;
		logic [31:0] now;
	} msg_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  sender;
		logic [7:0]  receiver;
		logic [7:0]  code;
		logic [31:0] tag;
		logic        last;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        func;
	logic [7:0]  sender_id;
	logic [7:0]  receiver_id;
	logic [7:0]  msg_code;
	logic [31:0] due_time;
	logic [31:0] extra_tag;
	logic [31:0] current_time;
	logic        result_valid;
	logic [1:0]  kind;
	logic [7:0]  out_sender;
	logic [7:0]  out_receiver;
	logic [7:0]  out_code;
	logic [31:0] out_tag;
	logic        is_last;

	msg_item_t held_msgs[$];
	result_t   expected_results[$];
	int        fail_count  = 0;
	int        cycle_count = 0;
	logic      no_idle     = 1'b0;

	timed_message_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.sender_id    (sender_id),
		.receiver_id  (receiver_id),
		.msg_code     (msg_code),
		.due_time     (due_time),
		.extra_tag    (extra_tag),
		.current_time (current_time),
		.result_valid (result_valid),
		.kind         (kind),
		.out_sender   (out_sender),
		.out_receiver (out_receiver),
		.out_code     (out_code),
		.out_tag      (out_tag),
		.is_last      (is_last)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// sorted insert behind every entry whose time is not later
	function automatic void insert_sorted(logic [7:0] s, logic [7:0] r, logic [7:0] c,
			logic [31:0] due, logic [31:0] tag);
		msg_item_t m;
		int        pos;
		result_t   res;
		res = '0;
		res.last = 1'b1;
		if (held_msgs.size() >= QUEUE_DEPTH) begin
			res.kind = KIND_FULL;
		end else begin
			m = '0;
			m.sender = s;
			m.receiver = r;
			m.code = c;
			m.due = due;
			m.tag = tag;
			pos = 0;
			while (pos < held_msgs.size() && held_msgs[pos].due <= due)
				pos++;
			held_msgs.insert(pos, m);
			res.kind = KIND_ACCEPT;
		end
		expected_results.push_back(res);
	endfunction

	function automatic void dispatch_due(logic [31:0] now);
		int      n;
		int      i;
		result_t res;
		n = 0;
		while (n < held_msgs.size() && n < MAX_RESULTS && held_msgs[n].due < now)
			n++;
		for (i = 0; i < n; i++) begin
			res.kind = KIND_DISPATCH;
			res.sender = held_msgs[0].sender;
			res.receiver = held_msgs[0].receiver;
			res.code = held_msgs[0].code;
			res.tag = held_msgs[0].tag;
			res.last = (i == n - 1);
			expected_results.push_back(res);
			void'(held_msgs.pop_front());
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			if (func == FUNC_POST)
				insert_sorted(sender_id, receiver_id, msg_code, due_time, extra_tag);
			else
				dispatch_due(current_time);
		end
	end

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result();
		result_t want;
		if (expected_results.size() == 0) begin
			$display("%0t unexpected result: expected none actual kind %0d tag %h",
				$time, kind, out_tag);
			fail_count++;
		end else begin
			want = expected_results.pop_front();
			check_field("kind", 32'(want.kind), 32'(kind));
			check_field("out_sender", 32'(want.sender), 32'(out_sender));
			check_field("out_receiver", 32'(want.receiver), 32'(out_receiver));
			check_field("out_code", 32'(want.code), 32'(out_code));
			check_field("out_tag", want.tag, out_tag);
			check_field("is_last", 32'(want.last), 32'(is_last));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1)
			check_result();
	end

	function automatic msg_item_t post_msg(logic [7:0] s, logic [7:0] r, logic [7:0] c,
			logic [31:0] due, logic [31:0] tag);
		msg_item_t m;
		m.func = FUNC_POST;
		m.sender = s;
		m.receiver = r;
		m.code = c;
		m.due = due;
		m.tag = tag;
		m.now = $urandom();
		return m;
	endfunction

	function automatic msg_item_t tick_msg(logic [31:0] now);
		msg_item_t m;
		m.func = FUNC_TICK;
		m.sender = 8'($urandom_range(0, 255));
		m.receiver = 8'($urandom_range(0, 255));
		m.code = 8'($urandom_range(0, 255));
		m.due = $urandom();
		m.tag = $urandom();
		m.now = now;
		return m;
	endfunction

	function automatic msg_item_t rand_post(logic [31:0] due);
		return post_msg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), due, $urandom());
	endfunction

	// called at a rising edge, returns at the edge that takes the transaction
	task automatic send_item(input msg_item_t m);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		func <= m.func;
		sender_id <= m.sender;
		receiver_id <= m.receiver;
		msg_code <= m.code;
		due_time <= m.due;
		extra_tag <= m.tag;
		current_time <= m.now;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	task automatic test_full_queue();
		int i;
		for (i = 0; i < QUEUE_DEPTH; i++)
			send_item(rand_post($urandom_range(0, 1000)));
		send_item(rand_post($urandom_range(0, 1000)));
		send_item(tick_msg(32'hFFFF_FFFF));
	endtask

	task automatic test_equal_times();
		send_item(post_msg(8'd1, 8'd2, 8'd3, 32'd10, 32'h0000_0001));
		send_item(post_msg(8'd4, 8'd5, 8'd6, 32'd10, 32'h0000_0002));
		send_item(post_msg(8'd7, 8'd8, 8'd9, 32'd5, 32'h0000_0003));
		send_item(tick_msg(32'd11));
	endtask

	task automatic test_due_boundary();
		send_item(rand_post(32'd20));
		send_item(tick_msg(32'd20));
		send_item(tick_msg(32'd21));
	endtask

	task automatic test_field_extremes();
		send_item(post_msg(8'h00, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000));
		send_item(post_msg(8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_item(tick_msg(32'hFFFF_FFFF));
	endtask

	task automatic test_random_traffic();
		logic [31:0] clock_now;
		int          n;
		int          sel;
		clock_now = 32'd1000;
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 99);
			if (sel < 3)
				clock_now = $urandom();
			if (sel < 15)
				send_item(rand_post(clock_now));
			else if (sel < 50)
				send_item(rand_post(clock_now + $urandom_range(0, 60)));
			else if (sel < 55)
				send_item(rand_post($urandom()));
			else if (sel < 97) begin
				clock_now = clock_now + $urandom_range(0, 16);
				send_item(tick_msg(clock_now));
			end else if (sel < 99)
				send_item(tick_msg($urandom()));
			else
				send_item(tick_msg(32'hFFFF_FFFE));
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		func <= FUNC_POST;
		sender_id <= '0;
		receiver_id <= '0;
		msg_code <= '0;
		due_time <= '0;
		extra_tag <= '0;
		current_time <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_full_queue();
		test_equal_times();
		test_due_boundary();
		test_field_extremes();
		test_random_traffic();

		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
